// ----- rtl/keypad_poll_presence_fifo_unit_defines.svh -----
// Assertion macros used by the keypad poller checker.
`ifndef KEYPAD_POLL_PRESENCE_FIFO_UNIT_DEFINES_SVH
`define KEYPAD_POLL_PRESENCE_FIFO_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define KPPF_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define KPPF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/kppf_pkg.sv -----
// Package: types, codes and sizes for the keypad poller.
`timescale 1ns / 1ps
`default_nettype none
package kppf_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;

	localparam logic [15:0] POLL_INTERVAL_RST  = 16'd20;
	localparam logic [15:0] PROBE_INTERVAL_RST = 16'd2000;
	localparam logic [3:0]  MISS_LIMIT_RST     = 4'd3;
	localparam logic [7:0]  NO_KEY_CODE_RST    = 8'd0;
	localparam logic [3:0]  MISS_STREAK_MAX    = 4'd15;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_POP   = 2'd1,
		OP_EVENT = 2'd2,
		OP_FLUSH = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_POLL_INTERVAL  = 2'd0,
		REG_PROBE_INTERVAL = 2'd1,
		REG_MISS_LIMIT     = 2'd2,
		REG_NO_KEY_CODE    = 2'd3
	} reg_idx_t;

	function automatic logic [QIDX_W-1:0] ring_next(input logic [QIDX_W-1:0] idx);
		logic [QIDX_W-1:0] res;
		if (idx == QIDX_W'(QUEUE_DEPTH - 1)) begin
			res = '0;
		end else begin
			res = idx + QIDX_W'(1);
		end
		return res;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/keypad_poll_presence_fifo_unit.sv -----
// Throughput: one request per cycle unless rsp_stall holds the result. Each request is
// one compare/add, counter update and a single access to the 16-entry key ring, all done
// between the input register that takes it and the result register.
// Reset (arst_n low, async): control state, indices, presence and timing cleared;
// configuration back to defaults. Key ring contents are not cleared (read only when filled).
`timescale 1ns / 1ps
`default_nettype none
module keypad_poll_presence_fifo_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// request channel
	input  wire logic                             req_valid,
	output logic                                  req_stall,
	input  wire logic [1:0]                       op,
	input  wire logic [31:0]                      now_ms,
	input  wire logic                             port_free,
	input  wire logic                             bus_open_ok,
	input  wire logic                             read_acked,
	input  wire logic [7:0]                       read_byte,
	// result channel
	output logic                                  rsp_valid,
	input  wire logic                             rsp_stall,
	output logic                                  poll_issued,
	output logic                                  is_present,
	output logic                                  key_valid,
	output logic [7:0]                            key_code,
	output logic                                  attach_event,
	output logic                                  attach_state,
	output logic [4:0]                            queue_count,
	output logic                                  bus_open,
	// configuration port
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [kppf_pkg::CFG_ADDR_W-1:0]  paddr,
	input  wire logic [kppf_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [kppf_pkg::CFG_DATA_W-1:0]       prdata,
	output logic                                  pready
);

	localparam int QIDX_W = kppf_pkg::QIDX_W;
	localparam int QCNT_W = kppf_pkg::QCNT_W;

	// configuration registers
	logic [15:0] poll_interval_q;
	logic [15:0] probe_interval_q;
	logic [3:0]  miss_limit_q;
	logic [7:0]  no_key_code_q;

	kppf_pkg::reg_idx_t reg_idx;
	logic               cfg_wr;

	// input stage
	logic              v_s1;
	kppf_pkg::op_t     op_s1;
	logic [31:0]       now_s1;
	logic              port_free_s1;
	logic              open_ok_s1;
	logic              acked_s1;
	logic [7:0]        byte_s1;

	// block state
	logic [7:0]        key_store_q [kppf_pkg::QUEUE_DEPTH];
	logic [QIDX_W-1:0] wr_idx_q;
	logic [QIDX_W-1:0] rd_idx_q;
	logic [QCNT_W-1:0] fill_q;
	logic              bus_q;
	logic              present_q;
	logic [3:0]        streak_q;
	logic [31:0]       next_poll_q;
	logic              ev_pend_q;
	logic              ev_state_q;

	// next-state values
	logic [QIDX_W-1:0] wr_idx_d;
	logic [QIDX_W-1:0] rd_idx_d;
	logic [QCNT_W-1:0] fill_d;
	logic              bus_d;
	logic              present_d;
	logic [3:0]        streak_d;
	logic [31:0]       next_poll_d;
	logic              ev_pend_d;
	logic              ev_state_d;
	logic              push;
	logic              polled;
	logic              kvalid;
	logic [7:0]        kcode;
	logic              ev;
	logic              evs;
	logic [31:0]       since;
	logic [15:0]       interval;
	logic [3:0]        streak_inc;
	logic              adv;

	// result register
	logic              rsp_valid_q;
	logic              polled_q;
	logic              present_out_q;
	logic              kvalid_q;
	logic [7:0]        kcode_q;
	logic              ev_q;
	logic              evs_q;
	logic [QCNT_W-1:0] fill_out_q;
	logic              bus_out_q;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign reg_idx = kppf_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_comb begin
		unique case (reg_idx)
			kppf_pkg::REG_POLL_INTERVAL:  prdata = {16'd0, poll_interval_q};
			kppf_pkg::REG_PROBE_INTERVAL: prdata = {16'd0, probe_interval_q};
			kppf_pkg::REG_MISS_LIMIT:     prdata = {28'd0, miss_limit_q};
			kppf_pkg::REG_NO_KEY_CODE:    prdata = {24'd0, no_key_code_q};
			default:                      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_interval_q  <= kppf_pkg::POLL_INTERVAL_RST;
			probe_interval_q <= kppf_pkg::PROBE_INTERVAL_RST;
			miss_limit_q     <= kppf_pkg::MISS_LIMIT_RST;
			no_key_code_q    <= kppf_pkg::NO_KEY_CODE_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				kppf_pkg::REG_POLL_INTERVAL:  poll_interval_q  <= pwdata[15:0];
				kppf_pkg::REG_PROBE_INTERVAL: probe_interval_q <= pwdata[15:0];
				kppf_pkg::REG_MISS_LIMIT:     miss_limit_q     <= pwdata[3:0];
				kppf_pkg::REG_NO_KEY_CODE:    no_key_code_q    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// ---------------- flow control ----------------
	assign adv       = !rsp_valid_q || !rsp_stall;
	assign req_stall = v_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!req_stall) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			op_s1        <= kppf_pkg::op_t'(op);
			now_s1       <= now_ms;
			port_free_s1 <= port_free;
			open_ok_s1   <= bus_open_ok;
			acked_s1     <= read_acked;
			byte_s1      <= read_byte;
		end
	end

	// ---------------- request evaluation ----------------
	assign since      = now_s1 - next_poll_q;
	assign streak_inc = (streak_q < kppf_pkg::MISS_STREAK_MAX) ? streak_q + 4'd1 : streak_q;

	// bus usable for the read: already claimed, or the claim succeeds now
	function automatic logic read_acked_ok();
		return bus_q || open_ok_s1;
	endfunction

	always_comb begin
		wr_idx_d    = wr_idx_q;
		rd_idx_d    = rd_idx_q;
		fill_d      = fill_q;
		bus_d       = bus_q;
		present_d   = present_q;
		streak_d    = streak_q;
		next_poll_d = next_poll_q;
		ev_pend_d   = ev_pend_q;
		ev_state_d  = ev_state_q;
		push        = 1'b0;
		polled      = 1'b0;
		kvalid      = 1'b0;
		kcode       = 8'd0;
		ev          = 1'b0;
		evs         = 1'b0;
		interval    = present_q ? poll_interval_q : probe_interval_q;

		case (op_s1)
			kppf_pkg::OP_TICK: begin
				if (!port_free_s1) begin
					// port taken: drop presence and release the bus
					if (present_q) begin
						present_d  = 1'b0;
						ev_pend_d  = 1'b1;
						ev_state_d = 1'b0;
						wr_idx_d   = '0;
						rd_idx_d   = '0;
						fill_d     = '0;
					end
					bus_d = 1'b0;
				end else if (!since[31]) begin
					if (read_acked_ok()) begin
						polled   = 1'b1;
						bus_d    = 1'b1;
						if (!acked_s1) begin
							if (present_q) begin
								streak_d = streak_inc;
								if (streak_inc >= miss_limit_q) begin
									present_d  = 1'b0;
									ev_pend_d  = 1'b1;
									ev_state_d = 1'b0;
									wr_idx_d   = '0;
									rd_idx_d   = '0;
									fill_d     = '0;
								end
							end
						end else begin
							streak_d = 4'd0;
							if (!present_q) begin
								present_d  = 1'b1;
								ev_pend_d  = 1'b1;
								ev_state_d = 1'b1;
							end
							if (byte_s1 != no_key_code_q) begin
								// key held: poll again at the fast rate
								push     = 1'b1;
								interval = poll_interval_q;
								wr_idx_d = kppf_pkg::ring_next(wr_idx_q);
								if (fill_q == QCNT_W'(kppf_pkg::QUEUE_DEPTH)) begin
									rd_idx_d = kppf_pkg::ring_next(rd_idx_q);
								end else begin
									fill_d = fill_q + QCNT_W'(1);
								end
							end
						end
					end
					next_poll_d = now_s1 + {16'd0, interval};
				end
			end
			kppf_pkg::OP_POP: begin
				if (fill_q == '0) begin
					kcode = no_key_code_q;
				end else begin
					kcode    = key_store_q[rd_idx_q];
					kvalid   = 1'b1;
					rd_idx_d = kppf_pkg::ring_next(rd_idx_q);
					fill_d   = fill_q - QCNT_W'(1);
				end
			end
			kppf_pkg::OP_EVENT: begin
				if (ev_pend_q) begin
					ev        = 1'b1;
					evs       = ev_state_q;
					ev_pend_d = 1'b0;
				end
			end
			kppf_pkg::OP_FLUSH: begin
				wr_idx_d = '0;
				rd_idx_d = '0;
				fill_d   = '0;
			end
			default: ;
		endcase
	end

	// ---------------- state update ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q    <= '0;
			rd_idx_q    <= '0;
			fill_q      <= '0;
			bus_q       <= 1'b0;
			present_q   <= 1'b0;
			streak_q    <= 4'd0;
			next_poll_q <= 32'd0;
			ev_pend_q   <= 1'b0;
			ev_state_q  <= 1'b0;
		end else if (v_s1 && adv) begin
			wr_idx_q    <= wr_idx_d;
			rd_idx_q    <= rd_idx_d;
			fill_q      <= fill_d;
			bus_q       <= bus_d;
			present_q   <= present_d;
			streak_q    <= streak_d;
			next_poll_q <= next_poll_d;
			ev_pend_q   <= ev_pend_d;
			ev_state_q  <= ev_state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && adv && push) begin
			key_store_q[wr_idx_q] <= byte_s1;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && adv) begin
			polled_q      <= polled;
			present_out_q <= present_d;
			kvalid_q      <= kvalid;
			kcode_q       <= kcode;
			ev_q          <= ev;
			evs_q         <= evs;
			fill_out_q    <= fill_d;
			bus_out_q     <= bus_d;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign poll_issued  = polled_q;
	assign is_present   = present_out_q;
	assign key_valid    = kvalid_q;
	assign key_code     = kcode_q;
	assign attach_event = ev_q;
	assign attach_state = evs_q;
	assign queue_count  = 5'(fill_out_q);
	assign bus_open     = bus_out_q;

endmodule
`default_nettype wire

// ----- rtl/kppf_checker.sv -----
// Port-level checker for the keypad poller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "keypad_poll_presence_fifo_unit_defines.svh"
module kppf_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       rsp_valid,
	input wire logic       rsp_stall,
	input wire logic       poll_issued,
	input wire logic       key_valid,
	input wire logic [7:0] key_code,
	input wire logic       attach_event,
	input wire logic       attach_state,
	input wire logic       bus_open
);

	// a read only happens on a claimed bus
	`KPPF_ASSERT_IMPLY(a_poll_bus, rsp_valid && poll_issued, bus_open, "poll without bus claim")
	// a request is a pop or an event take, never both
	`KPPF_ASSERT_IMPLY(a_op_excl, rsp_valid && key_valid, !attach_event && !poll_issued, "pop result mixed with other op")
	// attach state only reported with a pending event
	`KPPF_ASSERT_IMPLY(a_ev_state, rsp_valid && attach_state, attach_event, "attach state without event")
	// stalled result holds
	`KPPF_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(key_code) && $stable(bus_open), "stalled result changed")

endmodule

bind keypad_poll_presence_fifo_unit kppf_checker u_kppf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp_valid),
	.rsp_stall    (rsp_stall),
	.poll_issued  (poll_issued),
	.key_valid    (key_valid),
	.key_code     (key_code),
	.attach_event (attach_event),
	.attach_state (attach_state),
	.bus_open     (bus_open)
);
`default_nettype wire
